@@ design/rlrp_pkg.sv @@
// ----------------------------------------------------------------------------
// rlrp_pkg
// Shared types and constants of the radio link receive parser.
// ----------------------------------------------------------------------------
package rlrp_pkg;

  // Bytes with a meaning of their own on the link.
  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ACK   = 8'h06;
  localparam logic [7:0] CH_NAK   = 8'h15;
  localparam logic [7:0] CH_QUERY = 8'h53;

  // Frame command bytes.
  localparam logic [7:0] CMD_ACTIVE  = 8'h55;
  localparam logic [7:0] CMD_STANDBY = 8'h52;
  localparam logic [7:0] CMD_SWAP    = 8'h43;
  localparam logic [7:0] CMD_SETFREQ = 8'h5A;
  localparam logic [7:0] CMD_VOLUME  = 8'h41;

  // Frame lengths in bytes, STX included.
  localparam int FREQ_HDR_LEN = 5;
  localparam logic [3:0] SETFREQ_LEN = 4'd14;
  localparam logic [3:0] VOLUME_LEN  = 4'd6;

  localparam int NAME_LEN_DEFAULT = 8;
  localparam int NAME_BYTES_MAX   = 8;

  localparam int EVENT_W = 3;
  localparam int FREQ_W  = 18;
  localparam int NAME_W  = 8 * NAME_BYTES_MAX;

  typedef enum logic [EVENT_W-1:0] {
    EV_ACK     = 3'd0,
    EV_NAK     = 3'd1,
    EV_QUERY   = 3'd2,
    EV_ACTIVE  = 3'd3,
    EV_STANDBY = 3'd4,
    EV_SWAP    = 3'd5,
    EV_OTHER   = 3'd6,
    EV_CKSUM   = 3'd7
  } evt_t;

  typedef struct packed {
    evt_t              evt;
    logic [FREQ_W-1:0] freq_khz;
    logic [NAME_W-1:0] name;
  } result_t;

endpackage

@@ design/rlrp_parser.sv @@
// ----------------------------------------------------------------------------
// rlrp_parser
// Deframing state machine: consumes one byte per transfer and produces at
// most one result for it in the same cycle.
// ----------------------------------------------------------------------------
module rlrp_parser #(
  parameter int NAME_LEN = rlrp_pkg::NAME_LEN_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output rlrp_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  localparam logic [3:0] FREQ_LEN = 4'(rlrp_pkg::FREQ_HDR_LEN + NAME_LEN);
  localparam logic [3:0] NAME_END = 4'(4 + NAME_LEN);

  phase_t      phase, phase_next;
  logic [7:0]  frame_command, frame_command_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [3:0]  frame_length, frame_length_next;
  logic [7:0]  mega_hertz, mega_hertz_next;
  logic [7:0]  step_code, step_code_next;
  logic [7:0]  name_bytes [rlrp_pkg::NAME_BYTES_MAX];
  logic        name_we;
  logic [2:0]  name_idx;

  logic        is_freq;
  logic        is_last;
  logic [rlrp_pkg::FREQ_W-1:0] khz;
  logic [rlrp_pkg::NAME_W-1:0] name_flat;

  assign is_freq = (frame_command == rlrp_pkg::CMD_ACTIVE) ||
                   (frame_command == rlrp_pkg::CMD_STANDBY);
  assign is_last = ({1'b0, byte_count} + 5'd1) >= {1'b0, frame_length};
  assign name_idx = 3'(byte_count - 4'd4);

  assign khz = {10'd0, mega_hertz} * 18'd1000 + {10'd0, step_code} * 18'd5;

  always_comb begin
    for (int i = 0; i < rlrp_pkg::NAME_BYTES_MAX; i++) begin
      name_flat[8*i +: 8] = name_bytes[i];
    end
  end

  always_comb begin
    phase_next         = phase;
    frame_command_next = frame_command;
    byte_count_next    = byte_count;
    frame_length_next  = frame_length;
    mega_hertz_next    = mega_hertz;
    step_code_next     = step_code;
    name_we            = 1'b0;
    push               = 1'b0;
    res.evt            = rlrp_pkg::EV_OTHER;
    res.freq_khz       = '0;
    res.name           = '0;

    unique case (phase)
      PH_IDLE: begin
        priority if (rx_byte == rlrp_pkg::CH_STX) begin
          phase_next      = PH_CMD;
          byte_count_next = 4'd1;
        end else if (rx_byte == rlrp_pkg::CH_QUERY) begin
          push    = 1'b1;
          res.evt = rlrp_pkg::EV_QUERY;
        end else if (rx_byte == rlrp_pkg::CH_ACK) begin
          push    = 1'b1;
          res.evt = rlrp_pkg::EV_ACK;
        end else if (rx_byte == rlrp_pkg::CH_NAK) begin
          push    = 1'b1;
          res.evt = rlrp_pkg::EV_NAK;
        end else begin
          push    = 1'b1;
          res.evt = rlrp_pkg::EV_OTHER;
        end
      end

      PH_CMD: begin
        frame_command_next = rx_byte;
        byte_count_next    = 4'd2;
        mega_hertz_next    = '0;
        step_code_next     = '0;
        phase_next         = PH_BODY;
        priority if (rx_byte == rlrp_pkg::CMD_ACTIVE ||
                     rx_byte == rlrp_pkg::CMD_STANDBY) begin
          frame_length_next = FREQ_LEN;
        end else if (rx_byte == rlrp_pkg::CMD_SETFREQ) begin
          frame_length_next = rlrp_pkg::SETFREQ_LEN;
        end else if (rx_byte == rlrp_pkg::CMD_VOLUME) begin
          frame_length_next = rlrp_pkg::VOLUME_LEN;
        end else begin
          // Two-byte frame: done as soon as the command arrives.
          phase_next        = PH_IDLE;
          byte_count_next   = 4'd0;
          frame_length_next = 4'd0;
          push              = 1'b1;
          res.evt           = (rx_byte == rlrp_pkg::CMD_SWAP) ?
                              rlrp_pkg::EV_SWAP : rlrp_pkg::EV_OTHER;
        end
      end

      PH_BODY: begin
        byte_count_next = byte_count + 4'd1;
        if (is_freq && !is_last) begin
          if (byte_count == 4'd2) begin
            mega_hertz_next = rx_byte;
          end
          if (byte_count == 4'd3) begin
            step_code_next = rx_byte;
          end
          if (byte_count >= 4'd4 && byte_count < NAME_END) begin
            name_we = 1'b1;
          end
        end
        if (is_last) begin
          phase_next      = PH_IDLE;
          byte_count_next = 4'd0;
          push            = 1'b1;
          priority if (!is_freq) begin
            res.evt = rlrp_pkg::EV_OTHER;
          end else if (rx_byte != (mega_hertz ^ step_code)) begin
            res.evt = rlrp_pkg::EV_CKSUM;
          end else begin
            res.evt      = (frame_command == rlrp_pkg::CMD_ACTIVE) ?
                           rlrp_pkg::EV_ACTIVE : rlrp_pkg::EV_STANDBY;
            res.freq_khz = khz;
            res.name     = name_flat;
          end
        end
      end

      default: begin
        phase_next      = PH_IDLE;
        byte_count_next = 4'd0;
      end
    endcase

    push = push && take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      frame_command <= '0;
      byte_count    <= '0;
      frame_length  <= '0;
      mega_hertz    <= '0;
      step_code     <= '0;
      for (int i = 0; i < rlrp_pkg::NAME_BYTES_MAX; i++) begin
        name_bytes[i] <= '0;
      end
    end else if (take) begin
      phase         <= phase_next;
      frame_command <= frame_command_next;
      byte_count    <= byte_count_next;
      frame_length  <= frame_length_next;
      mega_hertz    <= mega_hertz_next;
      step_code     <= step_code_next;
      // The name is cleared when a new command opens a frame.
      if (phase == PH_CMD) begin
        for (int i = 0; i < rlrp_pkg::NAME_BYTES_MAX; i++) begin
          name_bytes[i] <= '0;
        end
      end else if (name_we) begin
        name_bytes[name_idx] <= rx_byte;
      end
    end
  end

`ifndef SYNTH
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (byte_count == 4'd0))
    else $error("byte count not cleared outside a frame");

  a_body_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (byte_count >= 4'd2 && byte_count < frame_length))
    else $error("frame position ran past the frame length");

  a_body_end: assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_BODY && is_last) |=> (phase == PH_IDLE))
    else $error("frame did not close after its last byte");
`endif

endmodule

@@ design/rlrp_out.sv @@
// ----------------------------------------------------------------------------
// rlrp_out
// Result register with a skid stage, so that the parser keeps taking bytes
// while a finished result waits on the output.
// ----------------------------------------------------------------------------
module rlrp_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rlrp_pkg::result_t res,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output rlrp_pkg::result_t out_res
);

  logic              skid_valid;
  rlrp_pkg::result_t skid_res;

  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (push) begin
      skid_res <= res;
    end
  end

`ifndef SYNTH
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && !out_ready) |=> skid_valid)
    else $error("result lost while the output was stalled");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid stage did not move to the output");
`endif

endmodule

@@ design/radio_link_receive_parser.sv @@
// ----------------------------------------------------------------------------
// radio_link_receive_parser
// Deframes the byte stream from a radio control unit into link events.
//
//   channel | direction | payload                                | handshake
//   --------+-----------+----------------------------------------+----------
//   in      | input     | rx_byte                                | valid/ready
//   out     | output    | event_res, freq_khz, label_chars       | valid/ready
//
// One byte is taken per cycle while in_ready is high. The result of a message
// is registered in the result register, or in the skid stage while the output
// stalls; the parser state and these two registers set the byte rate.
// Reset is synchronous and clears the parser to idle and empties the output.
// in_ready drops only while both the result register and the skid stage are
// full, so a stalled output stops input after two pending results.
// ----------------------------------------------------------------------------
module radio_link_receive_parser #(
  parameter int NAME_LEN = rlrp_pkg::NAME_LEN_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rlrp_pkg::EVENT_W-1:0]     event_res,
  output logic [rlrp_pkg::FREQ_W-1:0]      freq_khz,
  output logic [rlrp_pkg::NAME_W-1:0]      label_chars
);

  logic              take;
  logic              push;
  logic              space;
  rlrp_pkg::result_t res;
  rlrp_pkg::result_t out_res;

  assign in_ready = space;
  assign take     = in_valid && space;

  rlrp_parser #(
    .NAME_LEN (NAME_LEN)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .push    (push),
    .res     (res)
  );

  rlrp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign event_res   = out_res.evt;
  assign freq_khz    = out_res.freq_khz;
  assign label_chars = out_res.name;

endmodule
